### rtl/gsu_pkg.sv
// Shared types and constants for the GJK simplex update unit.
// Used by the controller, the datapath, the top level and the checker.
package gsu_pkg;

   // Default coordinate width, field widths fixed by the interface
   localparam int COORD_BITS_DEF = 16;
   localparam int PT_W           = 16;
   localparam int AXIS_W         = 51;

   // Operation codes of the input item
   localparam logic OP_START = 1'b0;
   localparam logic OP_ADD   = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_SIZE   = 2'd1,
      STAT_BEHIND = 2'd2
   } stat_type;

   // Vector registers of the datapath
   typedef enum logic [2:0] {
      V_AB, V_AC, V_AD, V_AO, V_N0, V_N1, V_N2, V_T
   } vsel_type;

   // Point reorder applied on commit
   typedef enum logic [1:0] {
      SH_KEEP,
      SH_DROP_B,
      SH_ACD,
      SH_ADB
   } shuf_type;

   // Controller states
   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH,
      ST_L_DOT, ST_L_X1, ST_L_X2,
      ST_T_X1, ST_T_X2, ST_T_D1, ST_T_X3, ST_T_X4, ST_T_D2, ST_T_X5, ST_T_D3,
      ST_Q_X1, ST_Q_X2, ST_Q_X3, ST_Q_D1, ST_Q_D2, ST_Q_D3,
      ST_COMMIT, ST_OUT
   } state_type;

   // Multiply-accumulate control, carried down the MAC pipeline
   typedef struct packed {
      logic       valid;
      logic       part;
      logic       neg;
      logic       clear;
      logic       wr;
      logic       wr_axis;
      vsel_type   dst;
      logic [1:0] comp;
   } mac_ctl_type;

   // Command from controller to datapath
   typedef struct packed {
      logic        capture;
      mac_ctl_type mac;
      vsel_type    a_vec;
      logic [1:0]  a_comp;
      vsel_type    b_vec;
      logic [1:0]  b_comp;
      logic        copy_en;
      vsel_type    copy_src;
      logic        copy_neg;
      logic        commit;
      logic        start;
      shuf_type    shuf;
      logic [2:0]  count;
      logic        set_hit;
      logic        stat_wr;
      stat_type    stat;
      logic        rsp_load;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic       op;
      logic [2:0] count;
      logic       dot_pos;
      logic       dot_neg;
      logic       rsp_busy;
   } sts_type;

   // Step counts of the MAC sequences
   localparam logic [3:0] CROSS_ISSUES = 4'd12;
   localparam logic [3:0] CROSS_LAST   = 4'd12;
   localparam logic [3:0] DOT_ISSUES   = 4'd6;
   localparam logic [3:0] DOT_LAST     = 4'd7;

endpackage

### rtl/gjk_simplex_update_unit.sv
// Cross and dot products run one after another on the one shared
// multiply-accumulate unit. One item is in work at a time; the result
// register frees the input side while a result waits. Synchronous reset empties
// the simplex, clears the colliding flag and the controller.
module gjk_simplex_update_unit #(
   parameter int COORD_BITS = gsu_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_op,
   input  logic signed [gsu_pkg::PT_W-1:0]   req_point_x,
   input  logic signed [gsu_pkg::PT_W-1:0]   req_point_y,
   input  logic signed [gsu_pkg::PT_W-1:0]   req_point_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [gsu_pkg::AXIS_W-1:0] rsp_axis_x,
   output logic signed [gsu_pkg::AXIS_W-1:0] rsp_axis_y,
   output logic signed [gsu_pkg::AXIS_W-1:0] rsp_axis_z,
   output logic                              rsp_colliding,
   output logic [2:0]                        rsp_simplex_size,
   output logic [1:0]                        rsp_status
);
   import gsu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gsu_datapath #(
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_op           (req_op),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_point_z      (req_point_z),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_axis_x       (rsp_axis_x),
      .rsp_axis_y       (rsp_axis_y),
      .rsp_axis_z       (rsp_axis_z),
      .rsp_colliding    (rsp_colliding),
      .rsp_simplex_size (rsp_simplex_size),
      .rsp_status       (rsp_status)
   );

endmodule

### rtl/gsu_ctrl.sv
// Controller of the GJK simplex update unit: sequences cross and dot products
// on the shared MAC, takes the region decisions and plans the commit. Uses gsu_pkg.
module gsu_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gsu_pkg::sts_type sts,
   output gsu_pkg::cmd_type cmd
);
   import gsu_pkg::*;

   state_type  state_ff, state_in;
   logic [3:0] step_ff, step_in;
   shuf_type   plan_shuf_ff, plan_shuf_in;
   logic [2:0] plan_cnt_ff, plan_cnt_in;
   logic       plan_hit_ff, plan_hit_in;

   function automatic logic [1:0] next_comp(logic [1:0] i);
      case (i)
         2'd0:    return 2'd1;
         2'd1:    return 2'd2;
         default: return 2'd0;
      endcase
   endfunction

   function automatic logic [1:0] prev_comp(logic [1:0] i);
      case (i)
         2'd0:    return 2'd2;
         2'd1:    return 2'd0;
         default: return 2'd1;
      endcase
   endfunction

   // Component i of a x b: a[j]*b[k] - a[k]*b[j], each term in two halves
   function automatic cmd_type cross_cmd(cmd_type c, vsel_type a, vsel_type b,
                                         vsel_type dst, logic to_axis, logic [3:0] s);
      cmd_type    r;
      logic [1:0] i;
      r = c;
      i = s[3:2];
      if (s < CROSS_ISSUES) begin
         r.mac.valid   = 1'b1;
         r.mac.part    = s[0];
         r.mac.clear   = (s[1:0] == 2'd0);
         r.mac.wr      = (s[1:0] == 2'd3);
         r.mac.wr_axis = to_axis;
         r.mac.dst     = dst;
         r.mac.comp    = i;
         r.a_vec       = a;
         r.b_vec       = b;
         if (!s[1]) begin
            r.a_comp  = next_comp(i);
            r.b_comp  = prev_comp(i);
            r.mac.neg = 1'b0;
         end else begin
            r.a_comp  = prev_comp(i);
            r.b_comp  = next_comp(i);
            r.mac.neg = 1'b1;
         end
      end
      return r;
   endfunction

   // Sum of a[i]*b[i], each term in two halves
   function automatic cmd_type dot_cmd(cmd_type c, vsel_type a, vsel_type b,
                                       logic [3:0] s);
      cmd_type r;
      r = c;
      if (s < DOT_ISSUES) begin
         r.mac.valid = 1'b1;
         r.mac.part  = s[0];
         r.mac.clear = (s == 4'd0);
         r.a_vec     = a;
         r.b_vec     = b;
         r.a_comp    = s[2:1];
         r.b_comp    = s[2:1];
      end
      return r;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);

   // Hold state, step counter and commit plan
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
      plan_shuf_ff <= plan_shuf_in;
      plan_cnt_ff  <= plan_cnt_in;
      plan_hit_ff  <= plan_hit_in;
   end

   // Next state and commands
   always_comb begin
      cmd          = cmd_type'('0);
      state_in     = state_ff;
      step_in      = step_ff + 4'd1;
      plan_shuf_in = plan_shuf_ff;
      plan_cnt_in  = plan_cnt_ff;
      plan_hit_in  = plan_hit_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            step_in = '0;
            if (sts.op == OP_START) begin
               cmd.commit = 1'b1;
               cmd.start  = 1'b1;
               cmd.count  = 3'd1;
               state_in   = ST_OUT;
            end else begin
               case (sts.count)
                  3'd1:    state_in = ST_L_DOT;
                  3'd2:    state_in = ST_T_X1;
                  3'd3:    state_in = ST_Q_X1;
                  default: begin
                     cmd.stat_wr = 1'b1;
                     cmd.stat    = STAT_SIZE;
                     state_in    = ST_OUT;
                  end
               endcase
            end
         end
         // Line region
         ST_L_DOT: begin
            cmd = dot_cmd(cmd, V_AB, V_AO, step_ff);
            if (step_ff == DOT_LAST) begin
               step_in = '0;
               if (sts.dot_neg) begin
                  cmd.stat_wr = 1'b1;
                  cmd.stat    = STAT_BEHIND;
                  state_in    = ST_OUT;
               end else begin
                  state_in = ST_L_X1;
               end
            end
         end
         ST_L_X1: begin
            cmd = cross_cmd(cmd, V_AB, V_AO, V_T, 1'b0, step_ff);
            if (step_ff == CROSS_LAST) begin
               step_in  = '0;
               state_in = ST_L_X2;
            end
         end
         ST_L_X2: begin
            cmd = cross_cmd(cmd, V_T, V_AB, V_T, 1'b1, step_ff);
            if (step_ff == CROSS_LAST) begin
               step_in      = '0;
               plan_shuf_in = SH_KEEP;
               plan_cnt_in  = 3'd2;
               plan_hit_in  = 1'b0;
               state_in     = ST_COMMIT;
            end
         end
         // Triangle region
         ST_T_X1: begin
            cmd = cross_cmd(cmd, V_AB, V_AC, V_N0, 1'b0, step_ff);
            if (step_ff == CROSS_LAST) begin
               step_in  = '0;
               state_in = ST_T_X2;
            end
         end
         ST_T_X2: begin
            cmd = cross_cmd(cmd, V_AC, V_AO, V_T, 1'b0, step_ff);
            if (step_ff == CROSS_LAST) begin
               step_in  = '0;
               state_in = ST_T_D1;
            end
         end
         ST_T_D1: begin
            cmd = dot_cmd(cmd, V_N0, V_T, step_ff);
            if (step_ff == DOT_LAST) begin
               step_in  = '0;
               state_in = sts.dot_pos ? ST_T_X3 : ST_T_X4;
            end
         end
         ST_T_X3: begin
            cmd = cross_cmd(cmd, V_N0, V_AC, V_T, 1'b1, step_ff);
            if (step_ff == CROSS_LAST) begin
               step_in      = '0;
               plan_shuf_in = SH_DROP_B;
               plan_cnt_in  = 3'd2;
               plan_hit_in  = 1'b0;
               state_in     = ST_COMMIT;
            end
         end
         ST_T_X4: begin
            cmd = cross_cmd(cmd, V_AO, V_AB, V_T, 1'b0, step_ff);
            if (step_ff == CROSS_LAST) begin
               step_in  = '0;
               state_in = ST_T_D2;
            end
         end
         ST_T_D2: begin
            cmd = dot_cmd(cmd, V_N0, V_T, step_ff);
            if (step_ff == DOT_LAST) begin
               step_in  = '0;
               state_in = sts.dot_pos ? ST_T_X5 : ST_T_D3;
            end
         end
         ST_T_X5: begin
            cmd = cross_cmd(cmd, V_AB, V_N0, V_T, 1'b1, step_ff);
            if (step_ff == CROSS_LAST) begin
               step_in      = '0;
               plan_shuf_in = SH_KEEP;
               plan_cnt_in  = 3'd2;
               plan_hit_in  = 1'b0;
               state_in     = ST_COMMIT;
            end
         end
         ST_T_D3: begin
            cmd = dot_cmd(cmd, V_N0, V_AO, step_ff);
            if (step_ff == DOT_LAST) begin
               step_in      = '0;
               cmd.copy_en  = 1'b1;
               cmd.copy_src = V_N0;
               cmd.copy_neg = !sts.dot_pos;
               plan_shuf_in = SH_KEEP;
               plan_cnt_in  = 3'd3;
               plan_hit_in  = 1'b0;
               state_in     = ST_COMMIT;
            end
         end
         // Tetrahedron region
         ST_Q_X1: begin
            cmd = cross_cmd(cmd, V_AB, V_AC, V_N0, 1'b0, step_ff);
            if (step_ff == CROSS_LAST) begin
               step_in  = '0;
               state_in = ST_Q_X2;
            end
         end
         ST_Q_X2: begin
            cmd = cross_cmd(cmd, V_AC, V_AD, V_N1, 1'b0, step_ff);
            if (step_ff == CROSS_LAST) begin
               step_in  = '0;
               state_in = ST_Q_X3;
            end
         end
         ST_Q_X3: begin
            cmd = cross_cmd(cmd, V_AD, V_AB, V_N2, 1'b0, step_ff);
            if (step_ff == CROSS_LAST) begin
               step_in  = '0;
               state_in = ST_Q_D1;
            end
         end
         ST_Q_D1: begin
            cmd = dot_cmd(cmd, V_N0, V_AO, step_ff);
            if (step_ff == DOT_LAST) begin
               step_in = '0;
               if (sts.dot_pos) begin
                  cmd.copy_en  = 1'b1;
                  cmd.copy_src = V_N0;
                  plan_shuf_in = SH_KEEP;
                  plan_cnt_in  = 3'd3;
                  plan_hit_in  = 1'b0;
                  state_in     = ST_COMMIT;
               end else begin
                  state_in = ST_Q_D2;
               end
            end
         end
         ST_Q_D2: begin
            cmd = dot_cmd(cmd, V_N1, V_AO, step_ff);
            if (step_ff == DOT_LAST) begin
               step_in = '0;
               if (sts.dot_pos) begin
                  cmd.copy_en  = 1'b1;
                  cmd.copy_src = V_N1;
                  plan_shuf_in = SH_ACD;
                  plan_cnt_in  = 3'd3;
                  plan_hit_in  = 1'b0;
                  state_in     = ST_COMMIT;
               end else begin
                  state_in = ST_Q_D3;
               end
            end
         end
         ST_Q_D3: begin
            cmd = dot_cmd(cmd, V_N2, V_AO, step_ff);
            if (step_ff == DOT_LAST) begin
               step_in = '0;
               if (sts.dot_pos) begin
                  cmd.copy_en  = 1'b1;
                  cmd.copy_src = V_N2;
                  plan_shuf_in = SH_ADB;
                  plan_cnt_in  = 3'd3;
                  plan_hit_in  = 1'b0;
               end else begin
                  // origin enclosed: keep all four points
                  plan_shuf_in = SH_KEEP;
                  plan_cnt_in  = 3'd4;
                  plan_hit_in  = 1'b1;
               end
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            step_in     = '0;
            cmd.commit  = 1'b1;
            cmd.shuf    = plan_shuf_ff;
            cmd.count   = plan_cnt_ff;
            cmd.set_hit = plan_hit_ff;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            step_in = '0;
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            step_in  = '0;
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/gsu_datapath.sv
// Datapath of the GJK simplex update unit: simplex store, edge and normal
// vectors, a two-stage shared multiply-accumulate and the result register. Uses gsu_pkg.
module gsu_datapath #(
   parameter int COORD_BITS = gsu_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_op,
   input  logic signed [gsu_pkg::PT_W-1:0]   req_point_x,
   input  logic signed [gsu_pkg::PT_W-1:0]   req_point_y,
   input  logic signed [gsu_pkg::PT_W-1:0]   req_point_z,
   input  gsu_pkg::cmd_type                  cmd,
   output gsu_pkg::sts_type                  sts,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [gsu_pkg::AXIS_W-1:0] rsp_axis_x,
   output logic signed [gsu_pkg::AXIS_W-1:0] rsp_axis_y,
   output logic signed [gsu_pkg::AXIS_W-1:0] rsp_axis_z,
   output logic                              rsp_colliding,
   output logic [2:0]                        rsp_simplex_size,
   output logic [1:0]                        rsp_status
);
   import gsu_pkg::*;

   localparam int DW    = COORD_BITS + 1;
   localparam int NW    = 2 * DW + 1;
   localparam int SPLIT = (NW + 1) / 2;
   localparam int PW    = NW + SPLIT + 1;
   localparam int ACC_W = 2 * NW + 2;

   // Simplex store, newest point first
   logic signed [COORD_BITS-1:0] pt_ff [4][3];
   logic signed [COORD_BITS-1:0] p_ff [3];
   logic signed [COORD_BITS-1:0] p_in [3];
   logic                         op_ff;
   logic [2:0]                   count_ff;
   logic                         hit_ff;
   stat_type                     status_ff;

   // Edge, normal and scratch vectors
   logic [2:0][NW-1:0] ab_ff, ac_ff, ad_ff, ao_ff, n0_ff, n1_ff, n2_ff, t_ff;
   logic [2:0][NW-1:0] a_row, b_row, c_row;
   logic [2:0][AXIS_W-1:0] axis_ff;

   // MAC pipeline
   logic signed [NW-1:0]    a_val, b_val;
   logic signed [SPLIT:0]   b_op;
   logic signed [PW-1:0]    prod_in, prod_ff;
   mac_ctl_type             ctl1_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, prod_ext, term_sh, term;

   // Result register
   logic                     rsp_valid_ff;
   logic signed [AXIS_W-1:0] rsp_ax_ff, rsp_ay_ff, rsp_az_ff;
   logic                     rsp_hit_ff;
   logic [2:0]               rsp_size_ff;
   stat_type                 rsp_stat_ff;

   assign p_in[0] = COORD_BITS'(req_point_x);
   assign p_in[1] = COORD_BITS'(req_point_y);
   assign p_in[2] = COORD_BITS'(req_point_z);

   // Select vector rows for the MAC operands and the axis copy
   function automatic logic [2:0][NW-1:0] pick(
      vsel_type sel,
      logic [2:0][NW-1:0] ab, logic [2:0][NW-1:0] ac, logic [2:0][NW-1:0] ad,
      logic [2:0][NW-1:0] ao, logic [2:0][NW-1:0] n0, logic [2:0][NW-1:0] n1,
      logic [2:0][NW-1:0] n2, logic [2:0][NW-1:0] t);
      case (sel)
         V_AB:    return ab;
         V_AC:    return ac;
         V_AD:    return ad;
         V_AO:    return ao;
         V_N0:    return n0;
         V_N1:    return n1;
         V_N2:    return n2;
         default: return t;
      endcase
   endfunction

   assign a_row = pick(cmd.a_vec, ab_ff, ac_ff, ad_ff, ao_ff, n0_ff, n1_ff, n2_ff, t_ff);
   assign b_row = pick(cmd.b_vec, ab_ff, ac_ff, ad_ff, ao_ff, n0_ff, n1_ff, n2_ff, t_ff);
   assign c_row = pick(cmd.copy_src, ab_ff, ac_ff, ad_ff, ao_ff, n0_ff, n1_ff, n2_ff, t_ff);

   // Stage 1: multiply the full a operand by one half of b
   assign a_val   = $signed(a_row[cmd.a_comp]);
   assign b_val   = $signed(b_row[cmd.b_comp]);
   assign b_op    = cmd.mac.part ? (SPLIT + 1)'(b_val >>> SPLIT)
                                 : $signed({1'b0, b_val[SPLIT-1:0]});
   assign prod_in = PW'(a_val) * PW'(b_op);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= mac_ctl_type'('0);
      end else begin
         ctl1_ff <= cmd.mac;
      end
      prod_ff <= prod_in;
   end

   // Stage 2: align, sign and accumulate
   assign prod_ext = ACC_W'(prod_ff);
   assign term_sh  = ctl1_ff.part ? (prod_ext <<< SPLIT) : prod_ext;
   assign term     = ctl1_ff.neg ? -term_sh : term_sh;
   assign acc_in   = (ctl1_ff.clear ? '0 : acc_ff) + term;

   always_ff @(posedge clock) begin
      if (ctl1_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // Capture the point, form edges, store MAC results and axis copies
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         for (int c = 0; c < 3; c++) begin
            p_ff[c]  <= p_in[c];
            ab_ff[c] <= NW'(pt_ff[0][c]) - NW'(p_in[c]);
            ac_ff[c] <= NW'(pt_ff[1][c]) - NW'(p_in[c]);
            ad_ff[c] <= NW'(pt_ff[2][c]) - NW'(p_in[c]);
            ao_ff[c] <= NW'(0) - NW'(p_in[c]);
         end
         axis_ff <= '0;
      end else if (cmd.copy_en) begin
         for (int c = 0; c < 3; c++) begin
            axis_ff[c] <= cmd.copy_neg ? -AXIS_W'($signed(c_row[c]))
                                       : AXIS_W'($signed(c_row[c]));
         end
      end else if (ctl1_ff.valid && ctl1_ff.wr) begin
         if (ctl1_ff.wr_axis) begin
            axis_ff[ctl1_ff.comp] <= AXIS_W'(acc_in);
         end else begin
            case (ctl1_ff.dst)
               V_N0:    n0_ff[ctl1_ff.comp] <= NW'(acc_in);
               V_N1:    n1_ff[ctl1_ff.comp] <= NW'(acc_in);
               V_N2:    n2_ff[ctl1_ff.comp] <= NW'(acc_in);
               default: t_ff[ctl1_ff.comp]  <= NW'(acc_in);
            endcase
         end
      end
   end

   // Commit the new simplex, or record an error
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         hit_ff    <= 1'b0;
         status_ff <= STAT_OK;
      end else begin
         if (cmd.capture) begin
            status_ff <= STAT_OK;
         end else if (cmd.stat_wr) begin
            status_ff <= cmd.stat;
         end
         if (cmd.commit) begin
            count_ff <= cmd.count;
            if (cmd.start) begin
               hit_ff <= 1'b0;
            end else if (cmd.set_hit) begin
               hit_ff <= 1'b1;
            end
         end
      end
      if (cmd.commit) begin
         pt_ff[0] <= p_ff;
         if (cmd.start) begin
            for (int c = 0; c < 3; c++) begin
               pt_ff[1][c] <= '0;
               pt_ff[2][c] <= '0;
               pt_ff[3][c] <= '0;
            end
         end else begin
            case (cmd.shuf)
               SH_DROP_B: begin
                  pt_ff[1] <= pt_ff[1];
                  pt_ff[2] <= pt_ff[1];
                  pt_ff[3] <= pt_ff[2];
               end
               SH_ACD: begin
                  pt_ff[1] <= pt_ff[1];
                  pt_ff[2] <= pt_ff[2];
                  pt_ff[3] <= pt_ff[2];
               end
               SH_ADB: begin
                  pt_ff[1] <= pt_ff[2];
                  pt_ff[2] <= pt_ff[0];
                  pt_ff[3] <= pt_ff[2];
               end
               default: begin
                  pt_ff[1] <= pt_ff[0];
                  pt_ff[2] <= pt_ff[1];
                  pt_ff[3] <= pt_ff[2];
               end
            endcase
         end
      end
   end

   // Load the result register; drop valid once the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_ax_ff   <= $signed(axis_ff[0]);
         rsp_ay_ff   <= $signed(axis_ff[1]);
         rsp_az_ff   <= $signed(axis_ff[2]);
         rsp_hit_ff  <= hit_ff;
         rsp_size_ff <= count_ff;
         rsp_stat_ff <= status_ff;
      end
   end

   assign sts.op       = op_ff;
   assign sts.count    = count_ff;
   assign sts.dot_neg  = acc_ff[ACC_W-1];
   assign sts.dot_pos  = !acc_ff[ACC_W-1] && (acc_ff != '0);
   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_axis_x       = rsp_ax_ff;
   assign rsp_axis_y       = rsp_ay_ff;
   assign rsp_axis_z       = rsp_az_ff;
   assign rsp_colliding    = rsp_hit_ff;
   assign rsp_simplex_size = rsp_size_ff;
   assign rsp_status       = rsp_stat_ff;

endmodule

### rtl/gsu_checker.sv
// Port-level checks for the GJK simplex update unit, bound to the top level.
// Uses gsu_pkg for field widths and status codes.
module gsu_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [gsu_pkg::AXIS_W-1:0] rsp_axis_x,
   input logic signed [gsu_pkg::AXIS_W-1:0] rsp_axis_y,
   input logic signed [gsu_pkg::AXIS_W-1:0] rsp_axis_z,
   input logic                              rsp_colliding,
   input logic [2:0]                        rsp_simplex_size,
   input logic [1:0]                        rsp_status
);
   import gsu_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_axis_x) &&
      $stable(rsp_status) && $stable(rsp_simplex_size))
      else $error("stalled result changed");

   // An error result carries a zero axis
   a_err_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != STAT_OK) |->
      (rsp_axis_x == '0) && (rsp_axis_y == '0) && (rsp_axis_z == '0))
      else $error("error result with nonzero axis");

   // Colliding only with a full tetrahedron
   a_hit_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_colliding |-> rsp_simplex_size == 3'd4)
      else $error("colliding with fewer than four points");

   // An empty simplex only shows with the size error
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_simplex_size == 3'd0) |-> rsp_status == STAT_SIZE)
      else $error("empty simplex without size error");

endmodule

bind gjk_simplex_update_unit gsu_checker u_gsu_checker (.*);
